[src/kahan_implicit_ode_step_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef KAHAN_IMPLICIT_ODE_STEP_MACROS_SVH
`define KAHAN_IMPLICIT_ODE_STEP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KIOS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("kios: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KIOS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("kios: assertion failed");

`endif

[src/kios_pkg.sv]
// ----------------------------------------------------------------------------
// kios_pkg
// Shared types, constants and the step microprogram of the Kahan ODE stepper.
// ----------------------------------------------------------------------------
package kios_pkg;

    localparam int unsigned VALUE_WIDTH_DEF = 32;
    localparam int unsigned FRAC_BITS_DEF   = 28;

    localparam int unsigned REG_AW = 5;
    localparam int unsigned UPC_W  = 6;

    typedef logic [REG_AW-1:0] t_raddr;
    typedef logic [UPC_W-1:0]  t_upc;

    typedef enum logic [3:0] {
        OP_MULF,
        OP_MULA,
        OP_ADD,
        OP_SUB,
        OP_MOV,
        OP_DIV,
        OP_LDH,
        OP_LDHALF,
        OP_LDONE,
        OP_CHKDET,
        OP_END
    } t_op;

    // Register file map. The first four entries are the architectural state.
    localparam t_raddr RA_Q1  = 5'd0;
    localparam t_raddr RA_Q2  = 5'd1;
    localparam t_raddr RA_P1  = 5'd2;
    localparam t_raddr RA_P2  = 5'd3;
    localparam t_raddr RA_H   = 5'd4;
    localparam t_raddr RA_HF  = 5'd5;
    localparam t_raddr RA_ON  = 5'd6;
    localparam t_raddr RA_R1  = 5'd7;
    localparam t_raddr RA_R2  = 5'd8;
    localparam t_raddr RA_C11 = 5'd9;
    localparam t_raddr RA_C12 = 5'd10;
    localparam t_raddr RA_C22 = 5'd11;
    localparam t_raddr RA_M11 = 5'd12;
    localparam t_raddr RA_M12 = 5'd13;
    localparam t_raddr RA_M22 = 5'd14;
    localparam t_raddr RA_S1  = 5'd15;
    localparam t_raddr RA_S2  = 5'd16;
    localparam t_raddr RA_DET = 5'd17;
    localparam t_raddr RA_T0  = 5'd18;
    localparam t_raddr RA_T1  = 5'd19;
    localparam t_raddr RA_N1  = 5'd20;
    localparam t_raddr RA_N2  = 5'd21;
    localparam t_raddr RA_NP1 = 5'd22;
    localparam t_raddr RA_NP2 = 5'd23;

    typedef struct packed {
        t_op    op;
        t_raddr dst;
        t_raddr srca;
        t_raddr srcb;
    } t_uop;

    typedef struct packed {
        logic load_state;
        logic load_h;
        logic rd;
        logic ex;
        logic div_step;
        logic wb;
        logic out_load;
        logic singular;
        t_uop uop;
    } t_dp_cmd;

    typedef struct packed {
        logic det_zero;
        logic div_done;
    } t_dp_stat;

    // One step of the method as a fixed sequence of register operations.
    function automatic t_uop uprog(input t_upc pc);
        t_uop u;
        case (pc)
            6'd0:  u = '{OP_LDH,    RA_H,   RA_Q1,  RA_Q1};
            6'd1:  u = '{OP_LDHALF, RA_HF,  RA_Q1,  RA_Q1};
            6'd2:  u = '{OP_LDONE,  RA_ON,  RA_Q1,  RA_Q1};
            6'd3:  u = '{OP_MULA,   RA_T0,  RA_H,   RA_P1};
            6'd4:  u = '{OP_ADD,    RA_R1,  RA_Q1,  RA_T0};
            6'd5:  u = '{OP_MULA,   RA_T0,  RA_H,   RA_P2};
            6'd6:  u = '{OP_ADD,    RA_R2,  RA_Q2,  RA_T0};
            6'd7:  u = '{OP_ADD,    RA_T0,  RA_Q2,  RA_HF};
            6'd8:  u = '{OP_MULF,   RA_C11, RA_H,   RA_T0};
            6'd9:  u = '{OP_MULF,   RA_C12, RA_H,   RA_Q1};
            6'd10: u = '{OP_SUB,    RA_T0,  RA_HF,  RA_Q2};
            6'd11: u = '{OP_MULF,   RA_C22, RA_H,   RA_T0};
            6'd12: u = '{OP_MULA,   RA_T0,  RA_H,   RA_C11};
            6'd13: u = '{OP_ADD,    RA_M11, RA_ON,  RA_T0};
            6'd14: u = '{OP_MULA,   RA_M12, RA_H,   RA_C12};
            6'd15: u = '{OP_MULA,   RA_T0,  RA_H,   RA_C22};
            6'd16: u = '{OP_ADD,    RA_M22, RA_ON,  RA_T0};
            6'd17: u = '{OP_MULA,   RA_T0,  RA_H,   RA_Q1};
            6'd18: u = '{OP_SUB,    RA_S1,  RA_P1,  RA_T0};
            6'd19: u = '{OP_MULF,   RA_T0,  RA_C11, RA_R1};
            6'd20: u = '{OP_SUB,    RA_S1,  RA_S1,  RA_T0};
            6'd21: u = '{OP_MULF,   RA_T0,  RA_C12, RA_R2};
            6'd22: u = '{OP_SUB,    RA_S1,  RA_S1,  RA_T0};
            6'd23: u = '{OP_MULA,   RA_T0,  RA_H,   RA_Q2};
            6'd24: u = '{OP_SUB,    RA_S2,  RA_P2,  RA_T0};
            6'd25: u = '{OP_MULF,   RA_T0,  RA_C12, RA_R1};
            6'd26: u = '{OP_SUB,    RA_S2,  RA_S2,  RA_T0};
            6'd27: u = '{OP_MULF,   RA_T0,  RA_C22, RA_R2};
            6'd28: u = '{OP_SUB,    RA_S2,  RA_S2,  RA_T0};
            6'd29: u = '{OP_MULF,   RA_T0,  RA_M11, RA_M22};
            6'd30: u = '{OP_MULF,   RA_T1,  RA_M12, RA_M12};
            6'd31: u = '{OP_SUB,    RA_DET, RA_T0,  RA_T1};
            6'd32: u = '{OP_CHKDET, RA_DET, RA_DET, RA_DET};
            6'd33: u = '{OP_MULF,   RA_T0,  RA_S1,  RA_M22};
            6'd34: u = '{OP_MULF,   RA_T1,  RA_M12, RA_S2};
            6'd35: u = '{OP_SUB,    RA_N1,  RA_T0,  RA_T1};
            6'd36: u = '{OP_MULF,   RA_T0,  RA_M11, RA_S2};
            6'd37: u = '{OP_MULF,   RA_T1,  RA_M12, RA_S1};
            6'd38: u = '{OP_SUB,    RA_N2,  RA_T0,  RA_T1};
            6'd39: u = '{OP_DIV,    RA_NP1, RA_N1,  RA_DET};
            6'd40: u = '{OP_DIV,    RA_NP2, RA_N2,  RA_DET};
            6'd41: u = '{OP_MULA,   RA_T0,  RA_H,   RA_NP1};
            6'd42: u = '{OP_ADD,    RA_Q1,  RA_R1,  RA_T0};
            6'd43: u = '{OP_MULA,   RA_T0,  RA_H,   RA_NP2};
            6'd44: u = '{OP_ADD,    RA_Q2,  RA_R2,  RA_T0};
            6'd45: u = '{OP_MOV,    RA_P1,  RA_NP1, RA_NP1};
            6'd46: u = '{OP_MOV,    RA_P2,  RA_NP2, RA_NP2};
            default: u = '{OP_END,  RA_Q1,  RA_Q1,  RA_Q1};
        endcase
        return u;
    endfunction

endpackage

[src/kios_ifs.sv]
// ----------------------------------------------------------------------------
// kios_ifs
// Valid/ready channel interfaces for input and result beats.
// ----------------------------------------------------------------------------
interface kios_in_if import kios_pkg::*; #(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic signed [VALUE_WIDTH-1:0] init_pos_x;
    logic signed [VALUE_WIDTH-1:0] init_pos_y;
    logic signed [VALUE_WIDTH-1:0] init_mom_x;
    logic signed [VALUE_WIDTH-1:0] init_mom_y;
    logic        [VALUE_WIDTH-2:0] step_size;

    modport source (output valid, kind, init_pos_x, init_pos_y, init_mom_x, init_mom_y,
                    step_size, input ready);
    modport sink (input valid, kind, init_pos_x, init_pos_y, init_mom_x, init_mom_y,
                  step_size, output ready);
endinterface

interface kios_out_if import kios_pkg::*; #(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] new_pos_x;
    logic signed [VALUE_WIDTH-1:0] new_pos_y;
    logic signed [VALUE_WIDTH-1:0] new_mom_x;
    logic signed [VALUE_WIDTH-1:0] new_mom_y;
    logic                          singular;

    modport source (output valid, new_pos_x, new_pos_y, new_mom_x, new_mom_y, singular,
                    input ready);
    modport sink (input valid, new_pos_x, new_pos_y, new_mom_x, new_mom_y, singular,
                  output ready);
endinterface

[src/kios_ctrl.sv]
// ----------------------------------------------------------------------------
// kios_ctrl
// Sequencer that walks the step microprogram and drives the datapath.
// ----------------------------------------------------------------------------
module kios_ctrl import kios_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_kind,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EX,
        S_DIV,
        S_WB,
        S_FIN
    } t_state;

    t_state r_state;
    t_upc   r_pc;
    logic   r_sing;
    logic   r_out_valid;
    t_uop   w_uop;
    logic   w_accept;
    logic   w_fin_go;

    assign w_uop       = uprog(r_pc);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_fin_go    = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd            = '0;
        o_cmd.uop        = w_uop;
        o_cmd.singular   = r_sing;
        o_cmd.load_state = w_accept && !i_in_kind;
        o_cmd.load_h     = w_accept && i_in_kind;
        o_cmd.rd         = (r_state == S_RD) && (w_uop.op != OP_END);
        o_cmd.ex         = (r_state == S_EX);
        o_cmd.div_step   = (r_state == S_DIV) && !i_stat.div_done;
        o_cmd.wb         = (r_state == S_WB);
        o_cmd.out_load   = w_fin_go;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_sing      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result replaces the one being taken in the same cycle.
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_sing <= 1'b0;
                        r_pc   <= '0;
                        r_state <= i_in_kind ? S_RD : S_FIN;
                    end
                end
                S_RD: begin
                    r_state <= (w_uop.op == OP_END) ? S_FIN : S_EX;
                end
                S_EX: begin
                    if (w_uop.op == OP_CHKDET) begin
                        if (i_stat.det_zero) begin
                            r_sing  <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_pc    <= r_pc + 1'b1;
                            r_state <= S_RD;
                        end
                    end else if (w_uop.op == OP_DIV) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_WB;
                    end
                end
                S_DIV: begin
                    if (i_stat.div_done) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_pc    <= r_pc + 1'b1;
                    r_state <= S_RD;
                end
                S_FIN: begin
                    if (w_fin_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[src/kios_dp.sv]
// ----------------------------------------------------------------------------
// kios_dp
// Register file, shared multiplier, adder, serial divider and output register.
// ----------------------------------------------------------------------------
module kios_dp import kios_pkg::*; #(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_stat                      o_stat,
    input  logic signed [VALUE_WIDTH-1:0] i_init_pos_x,
    input  logic signed [VALUE_WIDTH-1:0] i_init_pos_y,
    input  logic signed [VALUE_WIDTH-1:0] i_init_mom_x,
    input  logic signed [VALUE_WIDTH-1:0] i_init_mom_y,
    input  logic        [VALUE_WIDTH-2:0] i_step_size,
    output logic signed [VALUE_WIDTH-1:0] o_new_pos_x,
    output logic signed [VALUE_WIDTH-1:0] o_new_pos_y,
    output logic signed [VALUE_WIDTH-1:0] o_new_mom_x,
    output logic signed [VALUE_WIDTH-1:0] o_new_mom_y,
    output logic                          o_singular
);

    localparam int unsigned VW    = VALUE_WIDTH;
    localparam int unsigned PW    = 2 * VW + 1;
    localparam int unsigned DW    = VW + FRAC_BITS;
    localparam int unsigned MW    = (PW > DW + 1) ? PW : DW + 1;
    localparam int unsigned CW    = $clog2(DW + 1);
    localparam int unsigned DEPTH = 2 ** REG_AW;

    localparam logic [VW-1:0] VMAX   = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMIN   = {1'b1, {(VW-1){1'b0}}};
    localparam logic [VW-1:0] ONE_V  = (FRAC_BITS <= VW - 2) ? (VW'(1) << FRAC_BITS) : VMAX;
    localparam logic [VW-1:0] HALF_V = (FRAC_BITS <= VW - 1) ? (VW'(1) << (FRAC_BITS - 1))
                                                             : VMAX;
    localparam logic [PW-1:0] RND_F  = PW'(1) << (FRAC_BITS - 1);
    localparam logic [PW-1:0] RND_A  = PW'(1) << FRAC_BITS;
    localparam logic [MW-1:0] LIM    = MW'(1) << (VW - 1);
    localparam logic [CW-1:0] DIV_N  = CW'(DW);

    logic [VW-1:0] r_st [4];
    logic [VW-1:0] r_mem [DEPTH];
    logic [VW-2:0] r_h;
    logic [VW-1:0] r_opa;
    logic [VW-1:0] r_opb;
    logic [PW-1:0] r_prod;
    logic          r_neg;
    logic          r_sh1;
    logic [VW:0]   r_sum;
    logic [DW-1:0] r_dq;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_ud;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_out [4];
    logic          r_out_sing;

    logic [VW-1:0] w_ua;
    logic [VW-1:0] w_ub;
    logic [VW:0]   w_rem2;
    logic          w_ge;
    logic [PW-1:0] w_prnd;
    logic [MW-1:0] w_mq;
    logic [MW-1:0] w_dq;
    logic [VW-1:0] w_res;

    function automatic logic [VW-1:0] mag(input logic [VW-1:0] x);
        return x[VW-1] ? (VW'(0) - x) : x;
    endfunction

    function automatic logic [VW-1:0] from_mag(input logic neg, input logic [MW-1:0] m);
        logic [VW-1:0] r;
        if (m >= LIM) begin
            r = neg ? VMIN : VMAX;
        end else begin
            r = neg ? (VW'(0) - m[VW-1:0]) : m[VW-1:0];
        end
        return r;
    endfunction

    function automatic logic [VW-1:0] rd_sel(input t_raddr a, input logic [VW-1:0] mv,
                                              input logic [VW-1:0] s0, input logic [VW-1:0] s1,
                                              input logic [VW-1:0] s2, input logic [VW-1:0] s3);
        logic [VW-1:0] r;
        case (a)
            RA_Q1:   r = s0;
            RA_Q2:   r = s1;
            RA_P1:   r = s2;
            RA_P2:   r = s3;
            default: r = mv;
        endcase
        return r;
    endfunction

    assign w_ua    = mag(r_opa);
    assign w_ub    = mag(r_opb);
    assign w_rem2  = {r_rem, r_dq[DW-1]};
    assign w_ge    = (w_rem2 >= {1'b0, r_ud});
    assign w_prnd  = r_prod + (r_sh1 ? RND_A : RND_F);
    assign w_mq    = r_sh1 ? MW'(w_prnd >> (FRAC_BITS + 1)) : MW'(w_prnd >> FRAC_BITS);
    assign w_dq    = MW'(r_dq) + MW'({r_rem, 1'b0} >= {1'b0, r_ud});

    always_comb begin
        case (i_cmd.uop.op)
            OP_MULF, OP_MULA: w_res = from_mag(r_neg, w_mq);
            OP_DIV:           w_res = from_mag(r_neg, w_dq);
            default: begin
                if (r_sum[VW] != r_sum[VW-1]) begin
                    w_res = r_sum[VW] ? VMIN : VMAX;
                end else begin
                    w_res = r_sum[VW-1:0];
                end
            end
        endcase
    end

    assign o_stat.det_zero = (r_opa == '0);
    assign o_stat.div_done = (r_cnt == '0);

    // Architectural state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[0] <= '0;
            r_st[1] <= '0;
            r_st[2] <= '0;
            r_st[3] <= '0;
        end else if (i_cmd.load_state) begin
            r_st[0] <= i_init_pos_x;
            r_st[1] <= i_init_pos_y;
            r_st[2] <= i_init_mom_x;
            r_st[3] <= i_init_mom_y;
        end else if (i_cmd.wb && (i_cmd.uop.dst < REG_AW'(4))) begin
            r_st[i_cmd.uop.dst[1:0]] <= w_res;
        end
    end

    // Scratch memory for intermediate terms of a step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wb && (i_cmd.uop.dst >= REG_AW'(4))) begin
            r_mem[i_cmd.uop.dst] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_opa <= rd_sel(i_cmd.uop.srca, r_mem[i_cmd.uop.srca],
                            r_st[0], r_st[1], r_st[2], r_st[3]);
            r_opb <= rd_sel(i_cmd.uop.srcb, r_mem[i_cmd.uop.srcb],
                            r_st[0], r_st[1], r_st[2], r_st[3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_h) begin
            r_h <= i_step_size;
        end
        if (i_cmd.ex) begin
            r_neg  <= r_opa[VW-1] ^ r_opb[VW-1];
            r_sh1  <= (i_cmd.uop.op == OP_MULA);
            r_prod <= PW'(w_ua * w_ub);
            case (i_cmd.uop.op)
                OP_ADD:    r_sum <= {r_opa[VW-1], r_opa} + {r_opb[VW-1], r_opb};
                OP_SUB:    r_sum <= {r_opa[VW-1], r_opa} - {r_opb[VW-1], r_opb};
                OP_LDH:    r_sum <= {2'b00, r_h};
                OP_LDHALF: r_sum <= {1'b0, HALF_V};
                OP_LDONE:  r_sum <= {1'b0, ONE_V};
                default:   r_sum <= {r_opa[VW-1], r_opa};
            endcase
        end
    end

    // Restoring divider, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.ex && (i_cmd.uop.op == OP_DIV)) begin
            r_cnt <= DIV_N;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ex && (i_cmd.uop.op == OP_DIV)) begin
            r_dq  <= DW'(w_ua) << FRAC_BITS;
            r_rem <= '0;
            r_ud  <= w_ub;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? VW'(w_rem2 - {1'b0, r_ud}) : w_rem2[VW-1:0];
            r_dq  <= {r_dq[DW-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out[0]   <= r_st[0];
            r_out[1]   <= r_st[1];
            r_out[2]   <= r_st[2];
            r_out[3]   <= r_st[3];
            r_out_sing <= i_cmd.singular;
        end
    end

    assign o_new_pos_x = r_out[0];
    assign o_new_pos_y = r_out[1];
    assign o_new_mom_x = r_out[2];
    assign o_new_mom_y = r_out[3];
    assign o_singular  = r_out_sing;

endmodule

[src/kahan_implicit_ode_step.sv]
// Values default to the Q4.28 format. A load beat goes straight to the finish state;
// a step beat runs 44 microcode operations, each through read, execute and write-back
// states, a determinant check that ends the step early when the determinant is zero,
// two serial divisions of VALUE_WIDTH+FRAC_BITS quotient bits each and the finish state.
// One item in flight; input ready returns the cycle after the result loads,
// later if an unread result blocks the output register. Reset clears state and valid.
// ----------------------------------------------------------------------------
// kahan_implicit_ode_step
// One step of Kahan's implicit method for a two-degree-of-freedom cubic
// potential, solved through a reduced 2x2 system in the new momenta.
// ----------------------------------------------------------------------------
module kahan_implicit_ode_step import kios_pkg::*; #(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kios_in_if.sink    i_in,
    kios_out_if.source o_out
);

    // The controller and the datapath talk only through these two structs.
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // The controller owns the handshakes: input ready is high only between
    // items, and the output valid is a register that is loaded when a
    // finished item's state is copied into the datapath's output register.
    kios_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_kind   (i_in.kind),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // The datapath holds the state, the scratch register file, one shared
    // multiplier with rounding and saturation, and a bit-serial divider.
    kios_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_init_pos_x (i_in.init_pos_x),
        .i_init_pos_y (i_in.init_pos_y),
        .i_init_mom_x (i_in.init_mom_x),
        .i_init_mom_y (i_in.init_mom_y),
        .i_step_size  (i_in.step_size),
        .o_new_pos_x  (o_out.new_pos_x),
        .o_new_pos_y  (o_out.new_pos_y),
        .o_new_mom_x  (o_out.new_mom_x),
        .o_new_mom_y  (o_out.new_mom_y),
        .o_singular   (o_out.singular)
    );

endmodule

[src/kios_checker.sv]
// ----------------------------------------------------------------------------
// kios_checker
// Port-level checks on the stepper's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`include "kahan_implicit_ode_step_macros.svh"

module kios_checker import kios_pkg::*; #(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [4*VALUE_WIDTH:0]     i_out_data
);

    `KIOS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `KIOS_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_data))
    `KIOS_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `KIOS_ASSERT_IMP(a_reset_quiet, i_clk, i_rst_n, $past(!i_rst_n), !i_out_valid)

endmodule

bind kahan_implicit_ode_step kios_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_kios_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  ({o_out.new_pos_x, o_out.new_pos_y, o_out.new_mom_x, o_out.new_mom_y,
                   o_out.singular})
);
